@@ src/lbm_pkg.sv @@
// Shared types, widths, lattice direction tables and arithmetic helpers
// for the D2Q9 BGK collision unit. No dependencies.
`timescale 1ns / 1ps
package lbm_pkg;

   localparam int NPOP        = 9;
   localparam int DATA_W      = 32;
   localparam int FRAC        = 28;
   localparam int OMEGA_FRAC  = 30;
   localparam int SUM_W       = 36;
   localparam int MAG_W       = 35;
   localparam int NUM_W       = 64;
   localparam int DEN_W       = 36;
   localparam int REM_W       = 37;
   localparam int QUO_W       = 34;
   localparam int DIV_STEPS   = 34;
   localparam int LANE_STAGES = 8;
   localparam int RW_W        = 34;
   localparam int USQ_W       = 36;
   localparam int SAT_W       = 48;
   localparam int PROD_W      = RW_W + DATA_W;

   localparam logic [DATA_W-1:0] RELAX_RESET = 32'h4000_0000;

   typedef logic signed [DATA_W-1:0] pop_type;
   typedef logic signed [1:0]        dir_type;

   typedef enum logic [1:0] {W_REST, W_AXIS, W_DIAG} weight_type;

   localparam dir_type DIR_ZERO = 2'sd0;
   localparam dir_type DIR_POS  = 2'sd1;
   localparam dir_type DIR_NEG  = -2'sd1;

   localparam dir_type DIR_X [NPOP] = '{DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG, DIR_ZERO,
                                        DIR_POS, DIR_NEG, DIR_NEG, DIR_POS};
   localparam dir_type DIR_Y [NPOP] = '{DIR_ZERO, DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG,
                                        DIR_POS, DIR_POS, DIR_NEG, DIR_NEG};
   localparam weight_type WCLASS [NPOP] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                                            W_DIAG, W_DIAG, W_DIAG, W_DIAG};

   localparam logic signed [SAT_W-1:0] Q_MAX_W = 48'sh0000_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0] Q_MIN_W = 48'shFFFF_8000_0000;
   localparam pop_type POP_MAX = 32'sh7FFF_FFFF;
   localparam pop_type POP_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic             q;
   } div_step_type;

   function automatic pop_type sat32(input logic signed [SAT_W-1:0] v);
      if (v > Q_MAX_W) begin
         return POP_MAX;
      end else if (v < Q_MIN_W) begin
         return POP_MIN;
      end
      return pop_type'(v[DATA_W-1:0]);
   endfunction

   function automatic div_step_type div_step(input logic [REM_W-1:0] rem,
                                             input logic nbit,
                                             input logic [DEN_W-1:0] den);
      logic [REM_W-1:0] sh;
      div_step_type r;
      sh = {rem[REM_W-2:0], nbit};
      if (sh >= {1'b0, den}) begin
         r.rem = sh - {1'b0, den};
         r.q   = 1'b1;
      end else begin
         r.rem = sh;
         r.q   = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ src/lbm_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lbm_pkg for widths and the division step.
`timescale 1ns / 1ps
module lbm_divider import lbm_pkg::*; (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [REM_W-1:0] rem_ff [DIV_STEPS];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS];
   logic [NUM_W-1:0] num_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [REM_W-1:0] rem_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [NUM_W-1:0] num_cur;
      logic [DEN_W-1:0] den_cur;
      div_step_type     step_in;

      if (k == 0) begin : g_first
         assign rem_cur = REM_W'(num >> DIV_STEPS);
         assign quo_cur = '0;
         assign num_cur = num;
         assign den_cur = den;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign num_cur = num_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      assign step_in = div_step(rem_cur, num_cur[DIV_STEPS-1-k], den_cur);

      always_ff @(posedge clock) begin
         rem_ff[k] <= step_in.rem;
         quo_ff[k] <= {quo_cur[QUO_W-2:0], step_in.q};
         num_ff[k] <= num_cur;
         den_ff[k] <= den_cur;
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

@@ src/lbm_lane.sv @@
// One direction lane: equilibrium polynomial, weighting and relaxation.
// Depends on lbm_pkg for types, widths and saturation.
`timescale 1ns / 1ps
module lbm_lane import lbm_pkg::*; (
   input  logic              clock,
   input  dir_type           dir_x,
   input  dir_type           dir_y,
   input  pop_type           ux,
   input  pop_type           uy,
   input  logic [USQ_W-1:0]  usq,
   input  logic [RW_W-1:0]   rw,
   input  logic [DATA_W-1:0] relax_rate,
   input  pop_type           f,
   output pop_type           relaxed,
   output pop_type           f_out
);

   localparam logic signed [SAT_W-1:0] ONE_Q = SAT_W'(1) << FRAC;

   pop_type f_ff [LANE_STAGES];

   logic signed [33:0] tx, ty, cu_in;
   logic [33:0]        cu_mag;
   logic [DATA_W-1:0]  acu_in;
   logic signed [33:0] cu_e_ff, cu_f_ff;
   logic [DATA_W-1:0]  acu_ff;
   logic [RW_W-1:0]    rw_e_ff, rw_f_ff, rw_g_ff;
   logic [63:0]        sq_in;
   logic [35:0]        cusq_ff;
   logic signed [SAT_W-1:0] cu_w, cq_w, us_w, poly_w;
   pop_type            poly_in, poly_ff;
   logic [DATA_W-1:0]  pm;
   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic               psign_ff;
   logic signed [SAT_W-1:0] feq_w;
   pop_type            feq_in, feq_ff;
   logic signed [SAT_W-1:0] d_w;
   logic [32:0]        dmag_in, dmag_ff;
   logic               dneg_ff, dneg_k_ff;
   logic [64:0]        dprod;
   logic [34:0]        dm_ff;
   logic signed [SAT_W-1:0] r_w;
   pop_type            relaxed_ff;

   always_comb begin
      case (dir_x)
         DIR_POS: tx = 34'(ux);
         DIR_NEG: tx = -34'(ux);
         default: tx = '0;
      endcase
      case (dir_y)
         DIR_POS: ty = 34'(uy);
         DIR_NEG: ty = -34'(uy);
         default: ty = '0;
      endcase
      cu_in  = tx + ty;
      cu_mag = cu_in[33] ? 34'(-cu_in) : 34'(cu_in);
      acu_in = (cu_mag[33:32] != 2'b00) ? '1 : cu_mag[DATA_W-1:0];
   end

   assign sq_in = 64'(acu_ff) * 64'(acu_ff);

   always_comb begin
      cu_w    = SAT_W'(cu_f_ff);
      cq_w    = SAT_W'(cusq_ff);
      us_w    = SAT_W'(usq);
      poly_w  = ONE_Q + ((cu_w <<< 1) + cu_w) + (((cq_w <<< 3) + cq_w) >>> 1)
                - (((us_w <<< 1) + us_w) >>> 1);
      poly_in = sat32(poly_w);
   end

   assign pm      = poly_ff[DATA_W-1] ? DATA_W'(-poly_ff) : DATA_W'(poly_ff);
   assign prod_in = PROD_W'(rw_g_ff) * PROD_W'(pm);

   always_comb begin
      feq_w  = psign_ff ? -SAT_W'(prod_ff >> FRAC) : SAT_W'(prod_ff >> FRAC);
      feq_in = sat32(feq_w);
   end

   always_comb begin
      d_w     = SAT_W'(feq_ff) - SAT_W'(f_ff[4]);
      dmag_in = d_w[SAT_W-1] ? 33'(-d_w) : 33'(d_w);
   end

   assign dprod = 65'(dmag_ff) * 65'(relax_rate);

   assign r_w = dneg_k_ff ? SAT_W'(f_ff[6]) - SAT_W'(dm_ff)
                          : SAT_W'(f_ff[6]) + SAT_W'(dm_ff);

   always_ff @(posedge clock) begin
      f_ff[0] <= f;
      for (int s = 1; s < LANE_STAGES; s++) begin
         f_ff[s] <= f_ff[s-1];
      end
      cu_e_ff    <= cu_in;
      acu_ff     <= acu_in;
      rw_e_ff    <= rw;
      cusq_ff    <= sq_in[63:FRAC];
      cu_f_ff    <= cu_e_ff;
      rw_f_ff    <= rw_e_ff;
      poly_ff    <= poly_in;
      rw_g_ff    <= rw_f_ff;
      prod_ff    <= prod_in;
      psign_ff   <= poly_ff[DATA_W-1];
      feq_ff     <= feq_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= d_w[SAT_W-1];
      dm_ff      <= dprod[64:OMEGA_FRAC];
      dneg_k_ff  <= dneg_ff;
      relaxed_ff <= sat32(r_w);
   end

   assign relaxed = relaxed_ff;
   assign f_out   = f_ff[LANE_STAGES-1];

endmodule

@@ src/lbm_d2q9_bgk_collision_unit.sv @@
// Top level of the D2Q9 BGK collision unit: moments, velocity division,
// nine direction lanes and the output merge. Depends on lbm_pkg,
// lbm_divider and lbm_lane.
`timescale 1ns / 1ps
// One lattice node enters per clock and its nine populations leave, relaxed
// or passed through on a bad density, on a one-cycle rsp_valid beat; the
// result pipe has no backpressure, so capture every beat. busy never rises
// and csr_ready is always high. Results pass the 34-stage bit-per-stage
// velocity dividers, the 8-stage lane pipeline and five framing registers;
// the density weights come from a reciprocal multiply delayed to match the
// dividers. Write relax_rate only while no node is in flight.
module lbm_d2q9_bgk_collision_unit import lbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pop_type           req_pop_0,
   input  pop_type           req_pop_1,
   input  pop_type           req_pop_2,
   input  pop_type           req_pop_3,
   input  pop_type           req_pop_4,
   input  pop_type           req_pop_5,
   input  pop_type           req_pop_6,
   input  pop_type           req_pop_7,
   input  pop_type           req_pop_8,
   output logic              rsp_valid,
   output pop_type           rsp_out_0,
   output pop_type           rsp_out_1,
   output pop_type           rsp_out_2,
   output pop_type           rsp_out_3,
   output pop_type           rsp_out_4,
   output pop_type           rsp_out_5,
   output pop_type           rsp_out_6,
   output pop_type           rsp_out_7,
   output pop_type           rsp_out_8,
   output logic              rsp_bad_density,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DATA_W-1:0] csr_data
);

   localparam logic [QUO_W-1:0] Q_HALF = QUO_W'(1) << (DATA_W-1);
   localparam int               RECIP_SHIFT = 39;
   localparam logic [17:0]      RECIP9_HI   = 18'h38E38;
   localparam logic [17:0]      RECIP9_LO   = 18'h38E39;

   typedef struct packed {
      logic bad;
      logic sx;
      logic sy;
      logic ovx;
      logic ovy;
   } side_type;

   function automatic pop_type vel_sat(input logic [QUO_W-1:0] q,
                                       input logic neg, input logic ov);
      if (!neg) begin
         if (ov || q >= Q_HALF) begin
            return POP_MAX;
         end
         return pop_type'(q[DATA_W-1:0]);
      end
      if (ov || q > Q_HALF) begin
         return POP_MIN;
      end
      return -pop_type'(q[DATA_W-1:0]);
   endfunction

   logic [DATA_W-1:0] relax_rate_ff;

   pop_type pa_in [NPOP];
   pop_type pa_ff [NPOP];
   logic    va_ff, vb_ff, vc_ff, vd_ff;

   logic signed [SUM_W-1:0] rho_in, mx_in, my_in, rho_ff, mx_ff, my_ff;
   pop_type pb_ff [NPOP];

   logic [SUM_W-1:0] rho_u;
   logic [MAG_W-1:0] amx, amy;
   logic [39:0]      rho_x16;
   side_type         side_in, side_c_ff;
   pop_type          pc_ff [NPOP];
   logic [NUM_W-1:0] nx_ff, ny_ff;
   logic [DEN_W-1:0] den_ff;

   logic [QUO_W-1:0] qx, qy;
   logic             sc_v_ff   [DIV_STEPS];
   side_type         sc_side_ff [DIV_STEPS];
   pop_type          sc_pop_ff [DIV_STEPS][NPOP];

   logic [53:0]      whi_ff, wlo_ff;
   logic [DEN_W-1:0] wn_ff, wn2_ff;
   logic [71:0]      wsum;
   logic [32:0]      q9_ff;
   logic [DEN_W-1:0] w9_prod;
   logic [3:0]       w9_rem;
   logic [1:0]       w9_frac;
   logic [RW_W-1:0]  w16_ff [DIV_STEPS-2];
   logic [RW_W-1:0]  w4_ff  [DIV_STEPS-2];
   logic [RW_W-1:0]  w1_ff  [DIV_STEPS-2];

   pop_type          ux_ff, uy_ff;
   logic [RW_W-1:0]  rw16_ff, rw4_ff, rw1_ff;
   pop_type          pd_ff [NPOP];
   logic             bad_d_ff;

   logic [DATA_W-1:0] ax, ay;
   logic [63:0]       ax2_ff, ay2_ff;
   logic [USQ_W-1:0]  usq_ff;
   logic [64:0]       sq_sum;

   logic vl_ff [LANE_STAGES];
   logic bl_ff [LANE_STAGES];

   pop_type lane_relaxed [NPOP];
   pop_type lane_f       [NPOP];
   pop_type out_ff       [NPOP];
   logic    rsp_valid_ff, bad_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_rate_ff <= RELAX_RESET;
      end else if (csr_valid && csr_ready) begin
         relax_rate_ff <= csr_data;
      end
   end

   assign pa_in[0] = req_pop_0;
   assign pa_in[1] = req_pop_1;
   assign pa_in[2] = req_pop_2;
   assign pa_in[3] = req_pop_3;
   assign pa_in[4] = req_pop_4;
   assign pa_in[5] = req_pop_5;
   assign pa_in[6] = req_pop_6;
   assign pa_in[7] = req_pop_7;
   assign pa_in[8] = req_pop_8;

   always_comb begin
      rho_in = '0;
      mx_in  = '0;
      my_in  = '0;
      for (int i = 0; i < NPOP; i++) begin
         rho_in = rho_in + SUM_W'(pa_ff[i]);
         if (DIR_X[i] == DIR_POS) begin
            mx_in = mx_in + SUM_W'(pa_ff[i]);
         end else if (DIR_X[i] == DIR_NEG) begin
            mx_in = mx_in - SUM_W'(pa_ff[i]);
         end
         if (DIR_Y[i] == DIR_POS) begin
            my_in = my_in + SUM_W'(pa_ff[i]);
         end else if (DIR_Y[i] == DIR_NEG) begin
            my_in = my_in - SUM_W'(pa_ff[i]);
         end
      end
   end

   always_comb begin
      rho_u       = rho_ff[SUM_W-1:0];
      amx         = mx_ff[SUM_W-1] ? MAG_W'(-mx_ff) : MAG_W'(mx_ff);
      amy         = my_ff[SUM_W-1] ? MAG_W'(-my_ff) : MAG_W'(my_ff);
      rho_x16     = 40'(rho_u) << 4;
      side_in.bad = (rho_ff <= 0);
      side_in.sx  = mx_ff[SUM_W-1];
      side_in.sy  = my_ff[SUM_W-1];
      side_in.ovx = (40'(amx) >= rho_x16);
      side_in.ovy = (40'(amy) >= rho_x16);
   end

   always_ff @(posedge clock) begin
      pa_ff     <= pa_in;
      rho_ff    <= rho_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      pb_ff     <= pa_ff;
      side_c_ff <= side_in;
      pc_ff     <= pb_ff;
      nx_ff     <= NUM_W'(amx) << FRAC;
      ny_ff     <= NUM_W'(amy) << FRAC;
      den_ff    <= rho_u;
   end

   lbm_divider u_div_x   (.clock(clock), .num(nx_ff),  .den(den_ff),           .quo(qx));
   lbm_divider u_div_y   (.clock(clock), .num(ny_ff),  .den(den_ff),           .quo(qy));

   // rho / 9 by reciprocal multiply, then rho*16/36, rho*4/36 and rho/36
   always_comb begin
      wsum    = (72'(whi_ff) << 18) + 72'(wlo_ff);
      w9_prod = (DEN_W'(q9_ff) << 3) + DEN_W'(q9_ff);
      w9_rem  = 4'(wn2_ff - w9_prod);
      if (w9_rem < 4'd3) begin
         w9_frac = 2'd0;
      end else if (w9_rem < 4'd5) begin
         w9_frac = 2'd1;
      end else if (w9_rem < 4'd7) begin
         w9_frac = 2'd2;
      end else begin
         w9_frac = 2'd3;
      end
   end

   always_ff @(posedge clock) begin
      whi_ff    <= 54'(den_ff) * 54'(RECIP9_HI);
      wlo_ff    <= 54'(den_ff) * 54'(RECIP9_LO);
      wn_ff     <= den_ff;
      q9_ff     <= wsum[71:RECIP_SHIFT];
      wn2_ff    <= wn_ff;
      w16_ff[0] <= (RW_W'(q9_ff) << 2) + RW_W'(w9_frac);
      w4_ff[0]  <= RW_W'(q9_ff);
      w1_ff[0]  <= RW_W'(q9_ff >> 2);
      for (int s = 1; s < DIV_STEPS-2; s++) begin
         w16_ff[s] <= w16_ff[s-1];
         w4_ff[s]  <= w4_ff[s-1];
         w1_ff[s]  <= w1_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      sc_side_ff[0] <= side_c_ff;
      sc_pop_ff[0]  <= pc_ff;
      for (int s = 1; s < DIV_STEPS; s++) begin
         sc_side_ff[s] <= sc_side_ff[s-1];
         sc_pop_ff[s]  <= sc_pop_ff[s-1];
      end
      ux_ff    <= vel_sat(qx, sc_side_ff[DIV_STEPS-1].sx, sc_side_ff[DIV_STEPS-1].ovx);
      uy_ff    <= vel_sat(qy, sc_side_ff[DIV_STEPS-1].sy, sc_side_ff[DIV_STEPS-1].ovy);
      rw16_ff  <= w16_ff[DIV_STEPS-3];
      rw4_ff   <= w4_ff[DIV_STEPS-3];
      rw1_ff   <= w1_ff[DIV_STEPS-3];
      pd_ff    <= sc_pop_ff[DIV_STEPS-1];
      bad_d_ff <= sc_side_ff[DIV_STEPS-1].bad;
   end

   assign ax     = ux_ff[DATA_W-1] ? DATA_W'(-ux_ff) : DATA_W'(ux_ff);
   assign ay     = uy_ff[DATA_W-1] ? DATA_W'(-uy_ff) : DATA_W'(uy_ff);
   assign sq_sum = 65'(ax2_ff) + 65'(ay2_ff);

   always_ff @(posedge clock) begin
      ax2_ff <= 64'(ax) * 64'(ax);
      ay2_ff <= 64'(ay) * 64'(ay);
      usq_ff <= USQ_W'(sq_sum >> FRAC);
   end

   for (genvar i = 0; i < NPOP; i++) begin : g_lane
      logic [RW_W-1:0] lane_rw;
      assign lane_rw = (WCLASS[i] == W_REST) ? rw16_ff :
                       (WCLASS[i] == W_AXIS) ? rw4_ff : rw1_ff;
      lbm_lane u_lane (
         .clock      (clock),
         .dir_x      (DIR_X[i]),
         .dir_y      (DIR_Y[i]),
         .ux         (ux_ff),
         .uy         (uy_ff),
         .usq        (usq_ff),
         .rw         (lane_rw),
         .relax_rate (relax_rate_ff),
         .f          (pd_ff[i]),
         .relaxed    (lane_relaxed[i]),
         .f_out      (lane_f[i])
      );
   end

   always_ff @(posedge clock) begin
      bl_ff[0] <= bad_d_ff;
      for (int s = 1; s < LANE_STAGES; s++) begin
         bl_ff[s] <= bl_ff[s-1];
      end
      for (int i = 0; i < NPOP; i++) begin
         out_ff[i] <= bl_ff[LANE_STAGES-1] ? lane_f[i] : lane_relaxed[i];
      end
      bad_ff <= bl_ff[LANE_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < DIV_STEPS; s++) begin
            sc_v_ff[s] <= 1'b0;
         end
         for (int s = 0; s < LANE_STAGES; s++) begin
            vl_ff[s] <= 1'b0;
         end
      end else begin
         va_ff      <= start && !busy;
         vb_ff      <= va_ff;
         vc_ff      <= vb_ff;
         sc_v_ff[0] <= vc_ff;
         for (int s = 1; s < DIV_STEPS; s++) begin
            sc_v_ff[s] <= sc_v_ff[s-1];
         end
         vd_ff    <= sc_v_ff[DIV_STEPS-1];
         vl_ff[0] <= vd_ff;
         for (int s = 1; s < LANE_STAGES; s++) begin
            vl_ff[s] <= vl_ff[s-1];
         end
         rsp_valid_ff <= vl_ff[LANE_STAGES-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bad_density = bad_ff;
   assign rsp_out_0       = out_ff[0];
   assign rsp_out_1       = out_ff[1];
   assign rsp_out_2       = out_ff[2];
   assign rsp_out_3       = out_ff[3];
   assign rsp_out_4       = out_ff[4];
   assign rsp_out_5       = out_ff[5];
   assign rsp_out_6       = out_ff[6];
   assign rsp_out_7       = out_ff[7];
   assign rsp_out_8       = out_ff[8];

endmodule
